[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values and the round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;
	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	localparam word_t IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam word_t RK [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
		32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
		32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
		32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
		32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
		32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction
endpackage

[hw/rtl/sha256_byte_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte channel
// Valid/ready channel carrying one message byte and an end mark.
// ----------------------------------------------------------------------------
interface sha256_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

[hw/rtl/sha256_digest_if.sv]
// ----------------------------------------------------------------------------
// SHA-256 digest channel
// Valid/ready channel carrying one digest word and its position.
// ----------------------------------------------------------------------------
interface sha256_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_number;
	logic        last_word;

	modport source (output valid, digest_word, word_number, last_word, input ready);
	modport sink (input valid, digest_word, word_number, last_word, output ready);
endinterface

[hw/rtl/sha256_message_hasher_core.sv]
// SHA-256 message hasher core.
// in_ch takes one word per handshake: a message byte (when byte_present is
// set) and an end-of-message mark. Bytes are packed big-endian into a
// 16-word block held in registers.
// The 64th byte starts a compression on one shared round unit, one round
// per cycle, followed by an add into the hash.
// An end mark pads the block, runs one or two compressions and then
// presents eight digest words on out_ch, word 0 first, one per cycle
// while the receiver is ready. The first digest word is valid once the
// last compression has been added into the hash.
// A stall simply holds the current word.
// Input ready is low during each compression and, at message end, until
// the last digest word is taken.
// Reset loads the initial hash values and clears the length and fill count.
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Byte packing, padding, iterative compression and digest output.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core (
	input logic clk,
	input logic arst_n,
	sha256_byte_if.sink     in_ch,
	sha256_digest_if.source out_ch
);
	import sha256_pkg::*;

	state_t      state_q;
	word_t       hash_q [8];
	word_t       blk_q  [16];
	word_t       v_q    [8];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic        final_q;  // compression belongs to message end
	logic        second_q; // a length block still follows
	logic        padded_q;
	logic [2:0]  onum_q;

	word_t w, t1, t2, wn;
	logic  accept;
	logic [5:0] p;

	assign accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.digest_word = hash_q[onum_q];
	assign out_ch.word_number = onum_q;
	assign out_ch.last_word = (onum_q == 3'd7);

	// Round unit: the block registers act as the rolling schedule window.
	always_comb begin
		wn = blk_q[0] + sig0(blk_q[1]) + blk_q[9] + sig1(blk_q[14]);
		w  = (rnd_q < 6'd16) ? blk_q[0] : wn;
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ RK[rnd_q] + w;
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		p  = fill_q + {5'd0, in_ch.byte_present};
	end

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			len_q    <= '0;
			rnd_q    <= '0;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			onum_q   <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= IV[i];
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.byte_present) begin
							if (fill_q[1:0] == 2'd0)
								blk_q[fill_q[5:2]] <= {in_ch.data_byte, 24'd0};
							else
								blk_q[fill_q[5:2]] <= blk_q[fill_q[5:2]]
									| (word_t'(in_ch.data_byte) << (5'd24 - {fill_q[1:0], 3'd0}));
							len_q  <= len_q + 64'd8;
							fill_q <= p;
						end
						final_q <= in_ch.end_of_message;
						if (in_ch.byte_present && fill_q == 6'd63) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
							for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
						end else if (in_ch.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// Place the 0x80 mark, clear the later words and append the
					// length when it fits in this block.
					for (int i = 0; i < 16; i++) begin
						if (fill_q < 6'd56 && i == 14) begin
							blk_q[i] <= len_q[63:32];
						end else if (fill_q < 6'd56 && i == 15) begin
							blk_q[i] <= len_q[31:0];
						end else if (4'(i) == fill_q[5:2]) begin
							case (fill_q[1:0])
								2'd0: blk_q[i] <= 32'h80000000;
								2'd1: blk_q[i] <= {blk_q[i][31:24], 24'h800000};
								2'd2: blk_q[i] <= {blk_q[i][31:16], 16'h8000};
								default: blk_q[i] <= {blk_q[i][31:8], 8'h80};
							endcase
						end else if (4'(i) > fill_q[5:2]) begin
							blk_q[i] <= '0;
						end
					end
					second_q <= (fill_q >= 6'd56);
					rnd_q <= '0;
					for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i+1];
					blk_q[15] <= w;
					for (int i = 1; i < 8; i++) begin
						if (i != 4) v_q[i] <= v_q[i-1];
					end
					v_q[4] <= v_q[3] + t1;
					v_q[0] <= t1 + t2;
					rnd_q  <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					if (second_q) begin
						// Length-only block after an overflowing pad.
						for (int i = 0; i < 14; i++) blk_q[i] <= '0;
						blk_q[14] <= len_q[63:32];
						blk_q[15] <= len_q[31:0];
						second_q  <= 1'b0;
						rnd_q     <= '0;
						for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i] + v_q[i];
						state_q   <= ST_ROUND;
					end else if (final_q) begin
						// A full block that ended the message still needs its pad.
						state_q <= padded_q ? ST_OUT : ST_PAD;
						onum_q  <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						onum_q <= onum_q + 3'd1;
						if (onum_q == 3'd7) begin
							state_q <= ST_IDLE;
							fill_q  <= '0;
							len_q   <= '0;
							final_q <= 1'b0;
							for (int i = 0; i < 8; i++) hash_q[i] <= IV[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Marks that the current message end has already been padded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) padded_q <= 1'b0;
		else if (state_q == ST_PAD) padded_q <= 1'b1;
		else if (state_q == ST_IDLE) padded_q <= 1'b0;
	end
endmodule

[hw/rtl/sha256_checker.sv]
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Checks digest ordering and busy behavior seen on the ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sha256_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] word_number,
	input logic       last_word
);
	// The last flag marks word seven only.
	`ASSERT_IMPL(a_last, clk, arst_n, out_valid, last_word == (word_number == 3'd7))
	// Input is never taken while a digest is shown.
	`ASSERT_IMPL(a_busy, clk, arst_n, out_valid, !in_ready)
	// Words advance by one on each taken word.
	`ASSERT_NEXT(a_step, clk, arst_n, out_valid && out_ready && !last_word,
		out_valid && word_number == $past(word_number) + 3'd1)
	// After the last word the block is ready again.
	`ASSERT_NEXT(a_done, clk, arst_n, out_valid && out_ready && last_word, in_ready)
endmodule

bind sha256_message_hasher_core sha256_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .word_number(out_ch.word_number),
	.last_word(out_ch.last_word)
);
